### rtl/olpi_pkg.sv
// ----------------------------------------------------------------------------
// olpi_pkg
// Shared types, codes and sizes for the ordered list with positional insert.
// ----------------------------------------------------------------------------
package olpi_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int OP_W     = 3;
    localparam int POS_W    = 6;
    localparam int LEN_W    = 6;
    localparam int ST_W     = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_POS  = 3'd2;
    localparam logic [OP_W-1:0] OP_REM_HEAD = 3'd3;
    localparam logic [OP_W-1:0] OP_LIST     = 3'd4;

    // status codes
    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd3;

    // chain actions
    localparam logic [1:0] ACT_HOLD   = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_ROTATE = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } olpi_cmd_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value_res;
        logic [ST_W-1:0]         status;
        logic                    is_last;
        logic [LEN_W-1:0]        length;
    } olpi_res_t;

    typedef struct packed {
        logic [1:0]       action;
        logic [IDX_W-1:0] ins_idx;
        logic [CNT_W-1:0] count;
    } olpi_chain_ctl_t;

endpackage

### rtl/olpi_cell.sv
// ----------------------------------------------------------------------------
// olpi_cell
// One list slot: loads a new entry, takes its left or right neighbor, or
// takes the head entry when it is the last occupied slot of a rotation.
// ----------------------------------------------------------------------------
module olpi_cell
    import olpi_pkg::*;
(
    input  logic                    clk,
    input  olpi_chain_ctl_t         ctl,
    input  logic [IDX_W-1:0]        index,
    input  logic signed [VAL_W-1:0] new_value,
    input  logic signed [VAL_W-1:0] left,
    input  logic signed [VAL_W-1:0] right,
    input  logic signed [VAL_W-1:0] head,
    output logic signed [VAL_W-1:0] value
);

    logic signed [VAL_W-1:0] value_reg;
    logic signed [VAL_W-1:0] value_next;
    logic [CNT_W-1:0]        pos_plus1;

    assign pos_plus1 = CNT_W'(index) + CNT_W'(1);

    always_comb
    begin
        value_next = value_reg;
        unique case (ctl.action)
            ACT_INSERT:
            begin
                if (index == ctl.ins_idx)
                begin
                    value_next = new_value;
                end
                else if (index > ctl.ins_idx)
                begin
                    value_next = left;
                end
            end
            ACT_ROTATE:
            begin
                // the last occupied slot wraps around to the head
                if (pos_plus1 < ctl.count)
                begin
                    value_next = right;
                end
                else if (pos_plus1 == ctl.count)
                begin
                    value_next = head;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

### rtl/olpi_ctrl.sv
// ----------------------------------------------------------------------------
// olpi_ctrl
// Command decode, entry count, read-out sequencing and the result register.
// ----------------------------------------------------------------------------
module olpi_ctrl
    import olpi_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  olpi_cmd_t               cmd,
    input  logic signed [VAL_W-1:0] head,
    output logic                    busy,
    output olpi_chain_ctl_t         ctl,
    output logic                    done,
    output olpi_res_t               result
);

    localparam int CMP_W = CNT_W + POS_W;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] left_reg;
    logic [CNT_W-1:0] left_next;
    logic             listing_reg;
    logic             listing_next;
    logic             done_reg;
    logic             done_next;
    olpi_res_t        result_reg;
    olpi_res_t        result_next;
    logic             accepted;
    logic             full;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] limit_ext;

    function automatic logic [LEN_W-1:0] to_len(input logic [CNT_W-1:0] c);
        logic [CNT_W+LEN_W-1:0] tmp;
        tmp = {{LEN_W{1'b0}}, c};
        return tmp[LEN_W-1:0];
    endfunction

    assign accepted  = start && !listing_reg;
    assign full      = (count_reg >= CNT_W'(CAPACITY));
    assign pos_ext   = CMP_W'(cmd.position);
    assign limit_ext = CMP_W'(count_reg) + CMP_W'(1);

    always_comb
    begin
        count_next   = count_reg;
        left_next    = left_reg;
        listing_next = listing_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        ctl.action   = ACT_HOLD;
        ctl.ins_idx  = '0;
        ctl.count    = count_reg;

        if (listing_reg)
        begin
            // one listed entry per cycle, the chain rotates under it
            ctl.action            = ACT_ROTATE;
            done_next             = 1'b1;
            result_next.value_res = head;
            result_next.status    = ST_OK;
            result_next.is_last   = (left_reg == CNT_W'(1));
            result_next.length    = to_len(count_reg);
            left_next             = left_reg - CNT_W'(1);
            listing_next          = (left_reg != CNT_W'(1));
        end
        else if (accepted)
        begin
            done_next             = 1'b1;
            result_next.value_res = '0;
            result_next.status    = ST_OK;
            result_next.is_last   = 1'b1;
            unique case (cmd.operation)
                OP_INS_HEAD, OP_INS_TAIL:
                begin
                    if (full)
                    begin
                        result_next.status = ST_FULL;
                    end
                    else
                    begin
                        ctl.action  = ACT_INSERT;
                        ctl.ins_idx = (cmd.operation == OP_INS_HEAD) ? '0
                                      : count_reg[IDX_W-1:0];
                        count_next  = count_reg + CNT_W'(1);
                    end
                end
                OP_INS_POS:
                begin
                    priority if (pos_ext == '0 || pos_ext > limit_ext)
                    begin
                        result_next.status = ST_BADPOS;
                    end
                    else if (full)
                    begin
                        result_next.status = ST_FULL;
                    end
                    else
                    begin
                        ctl.action  = ACT_INSERT;
                        ctl.ins_idx = IDX_W'(pos_ext - CMP_W'(1));
                        count_next  = count_reg + CNT_W'(1);
                    end
                end
                OP_REM_HEAD:
                begin
                    if (count_reg == '0)
                    begin
                        result_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        ctl.action            = ACT_ROTATE;
                        result_next.value_res = head;
                        count_next            = count_reg - CNT_W'(1);
                    end
                end
                OP_LIST:
                begin
                    if (count_reg == '0)
                    begin
                        result_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        ctl.action            = ACT_ROTATE;
                        result_next.value_res = head;
                        result_next.is_last   = (count_reg == CNT_W'(1));
                        left_next             = count_reg - CNT_W'(1);
                        listing_next          = (count_reg != CNT_W'(1));
                    end
                end
                default:
                begin
                    result_next.status = ST_OK;
                end
            endcase
            result_next.length = to_len(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            left_reg    <= '0;
            listing_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            left_reg    <= left_next;
            listing_reg <= listing_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = listing_reg;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

### rtl/ordered_list_positional_insert.sv
// ----------------------------------------------------------------------------
// ordered_list_positional_insert
// Bounded ordered list of signed 32-bit entries held in a row of cells.
// ----------------------------------------------------------------------------
// A command transfers on a rising edge with start high and busy low. Each
// result sits on result for one cycle with done high; the receiver cannot
// stall it, so it must take every result as it comes.
// Inserts shift the slots from the insert point right and head removal shifts
// the row left, at once, and the result appears the cycle after the transfer.
// List-all rotates the row one slot per cycle and emits the head each time,
// so it gives count results (1 to 32), one result per cycle, the first one
// the cycle after the transfer; busy stays high until the last one is issued,
// and after count rotations the row is back in its original order.
// Throughput is one command per cycle, except while list-all holds the
// block busy until its last result is issued.
// Reset clears the entry count and the sequencer; slot contents are not
// cleared and are only read below the count.
// ----------------------------------------------------------------------------
module ordered_list_positional_insert
    import olpi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  olpi_cmd_t cmd,
    output logic      busy,
    output logic      done,
    output olpi_res_t result
);

    olpi_chain_ctl_t         ctl;
    logic signed [VAL_W-1:0] slot [CAPACITY];

    olpi_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .head   (slot[0]),
        .busy   (busy),
        .ctl    (ctl),
        .done   (done),
        .result (result)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        olpi_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .index     (IDX_W'(i)),
            .new_value (cmd.value),
            .left      (slot[(i == 0) ? 0 : i - 1]),
            .right     (slot[(i == CAPACITY - 1) ? 0 : i + 1]),
            .head      (slot[0]),
            .value     (slot[i])
        );
    end

endmodule

### dv/ordered_list_positional_insert_test.sv
// ----------------------------------------------------------------------------
// ordered_list_positional_insert_test
// Self-checking bench for the ordered list: random command traffic with
// random gaps, a shadow list that predicts every result, and a strobe monitor
// that checks each result in order against the predicted ones.
// ----------------------------------------------------------------------------
module ordered_list_positional_insert_test;
    import olpi_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM    = 460;
    localparam int STALL_LIMIT = 2000;
    localparam int IDLE_PCT    = 21;

    // operation codes that the block treats as no-ops
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    typedef enum int { MODE_GROW, MODE_SHRINK, MODE_NOISE } traffic_mode_t;

    typedef struct {
        olpi_cmd_t cmd;
        bit        drain_first;
        bit        steady;
    } queued_cmd_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    olpi_cmd_t cmd = '0;
    logic      busy;
    logic      done;
    olpi_res_t result;

    queued_cmd_t             pending_cmds[$];
    olpi_res_t               due_results[$];
    logic signed [VAL_W-1:0] list_shadow[$];

    int  shadow_count;
    int  queued_total;
    int  cmds_sent;
    int  results_checked;
    int  mismatch_count;
    int  stall_cycles;
    int  n_list_reads;
    int  n_full;
    int  n_badpos;
    int  n_empty;
    bit  launch;

    ordered_list_positional_insert u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always #5 clk = ~clk;

    function automatic olpi_res_t list_result(logic signed [VAL_W-1:0] v, logic [ST_W-1:0] st,
                                              logic last);
        olpi_res_t r;
        r.value_res = v;
        r.status    = st;
        r.is_last   = last;
        r.length    = LEN_W'(list_shadow.size());
        return r;
    endfunction

    // shadow list update and expected results for one accepted command
    task automatic apply_list_cmd(olpi_cmd_t c);
        int                      cnt;
        logic signed [VAL_W-1:0] head_val;
        cnt = list_shadow.size();
        case (c.operation)
            OP_INS_HEAD, OP_INS_TAIL:
            begin
                if (cnt >= CAPACITY)
                begin
                    n_full++;
                    due_results.push_back(list_result('0, ST_FULL, 1'b1));
                end
                else
                begin
                    if (c.operation == OP_INS_HEAD)
                        list_shadow.push_front(c.value);
                    else
                        list_shadow.push_back(c.value);
                    due_results.push_back(list_result('0, ST_OK, 1'b1));
                end
            end
            OP_INS_POS:
            begin
                // range check wins over the full check
                if (c.position < 1 || int'(c.position) > cnt + 1)
                begin
                    n_badpos++;
                    due_results.push_back(list_result('0, ST_BADPOS, 1'b1));
                end
                else if (cnt >= CAPACITY)
                begin
                    n_full++;
                    due_results.push_back(list_result('0, ST_FULL, 1'b1));
                end
                else
                begin
                    list_shadow.insert(int'(c.position) - 1, c.value);
                    due_results.push_back(list_result('0, ST_OK, 1'b1));
                end
            end
            OP_REM_HEAD:
            begin
                if (cnt == 0)
                begin
                    n_empty++;
                    due_results.push_back(list_result('0, ST_EMPTY, 1'b1));
                end
                else
                begin
                    head_val = list_shadow.pop_front();
                    due_results.push_back(list_result(head_val, ST_OK, 1'b1));
                end
            end
            OP_LIST:
            begin
                if (cnt == 0)
                begin
                    n_empty++;
                    due_results.push_back(list_result('0, ST_EMPTY, 1'b1));
                end
                else
                begin
                    n_list_reads++;
                    foreach (list_shadow[i])
                        due_results.push_back(list_result(list_shadow[i], ST_OK, i == cnt - 1));
                end
            end
            default:
                due_results.push_back(list_result('0, ST_OK, 1'b1));
        endcase
    endtask

    // ------------------------------------------------------------------
    // stimulus generation
    // ------------------------------------------------------------------
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // valid most of the time, otherwise zero or past the end of the list
    function automatic logic [POS_W-1:0] pick_position(int cnt);
        if ($urandom_range(0, 99) < 85)
            return POS_W'($urandom_range(1, cnt + 1));
        else if ($urandom_range(0, 1) == 0)
            return '0;
        else
            return POS_W'($urandom_range(cnt + 2, 63));
    endfunction

    task automatic queue_cmd(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] v,
                             logic [POS_W-1:0] pos, bit drain);
        queued_cmd_t q;
        q.cmd.operation = op;
        q.cmd.value     = v;
        q.cmd.position  = pos;
        q.drain_first   = drain;
        q.steady        = (queued_total >= 150 && queued_total < 250);
        pending_cmds.push_back(q);
        queued_total++;
        // rough count kept only to aim positions
        case (op)
            OP_INS_HEAD, OP_INS_TAIL:
                if (shadow_count < CAPACITY) shadow_count++;
            OP_INS_POS:
                if (pos >= 1 && int'(pos) <= shadow_count + 1 && shadow_count < CAPACITY)
                    shadow_count++;
            OP_REM_HEAD:
                if (shadow_count > 0) shadow_count--;
            default: ;
        endcase
    endtask

    task automatic queue_random_traffic();
        traffic_mode_t   mode;
        int              burst;
        int              made;
        int              roll;
        logic [OP_W-1:0] op;
        made = 0;
        while (made < N_RANDOM)
        begin
            mode  = traffic_mode_t'($urandom_range(0, 2));
            burst = $urandom_range(8, 40);
            for (int k = 0; k < burst && made < N_RANDOM; k++)
            begin
                roll = $urandom_range(0, 99);
                case (mode)
                    MODE_GROW:
                        op = (roll < 25) ? OP_INS_HEAD : (roll < 50) ? OP_INS_TAIL :
                             (roll < 85) ? OP_INS_POS  : (roll < 95) ? OP_LIST : OP_REM_HEAD;
                    MODE_SHRINK:
                        op = (roll < 60) ? OP_REM_HEAD : (roll < 70) ? OP_LIST :
                             (roll < 80) ? OP_INS_HEAD : (roll < 90) ? OP_INS_TAIL : OP_INS_POS;
                    default:
                        op = OP_W'($urandom_range(0, OP_SPARE_HI));
                endcase
                queue_cmd(op, pick_value(),
                          (mode == MODE_NOISE) ? POS_W'($urandom_range(0, 63))
                                               : pick_position(shadow_count),
                          made == 0 || $urandom_range(0, 99) == 0);
                made++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // driver: one command transfer at a time, random gaps between them
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd   <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                apply_list_cmd(cmd);
                cmds_sent++;
            end
            if (!(start && busy))
            begin
                launch = 1'b0;
                if (pending_cmds.size() != 0)
                begin
                    if (pending_cmds[0].drain_first && due_results.size() != 0)
                        launch = 1'b0;
                    else if (pending_cmds[0].steady || $urandom_range(0, 99) >= IDLE_PCT)
                        launch = 1'b1;
                end
                if (launch)
                begin
                    cmd   <= pending_cmds[0].cmd;
                    start <= 1'b1;
                    pending_cmds.delete(0);
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: every strobed result is checked against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        olpi_res_t want;
        if (rst_n && done)
        begin
            if (due_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, got %p", $time, result);
            end
            else
            begin
                want = due_results.pop_front();
                results_checked++;
                if (result.value_res !== want.value_res)
                begin
                    mismatch_count++;
                    $display("%0t: value_res expected %0d got %0d", $time,
                             want.value_res, result.value_res);
                end
                if (result.status !== want.status)
                begin
                    mismatch_count++;
                    $display("%0t: status expected %0d got %0d", $time, want.status,
                             result.status);
                end
                if (result.is_last !== want.is_last)
                begin
                    mismatch_count++;
                    $display("%0t: is_last expected %0d got %0d", $time, want.is_last,
                             result.is_last);
                end
                if (result.length !== want.length)
                begin
                    mismatch_count++;
                    $display("%0t: length expected %0d got %0d", $time, want.length,
                             result.length);
                end
            end
        end
    end

    // watchdog on cycles with no transfer in either direction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        shadow_count = 0;
        queued_total = 0;

        // empty-list cases, position edges and value extremes
        queue_cmd(OP_LIST,     '0, '0, 1'b0);
        queue_cmd(OP_REM_HEAD, '0, '0, 1'b0);
        queue_cmd(OP_INS_POS,  pick_value(), 6'd0, 1'b0);
        queue_cmd(OP_INS_POS,  pick_value(), 6'd2, 1'b0);
        queue_cmd(OP_INS_POS,  32'sh7fff_ffff, 6'd1, 1'b0);
        queue_cmd(OP_INS_HEAD, 32'sh8000_0000, '0, 1'b0);
        queue_cmd(OP_INS_TAIL, '1, '1, 1'b0);
        queue_cmd(OP_INS_POS,  '0, 6'd4, 1'b0);
        queue_cmd(OP_INS_POS,  pick_value(), 6'd63, 1'b0);
        queue_cmd(OP_INS_POS,  32'sd123, 6'd2, 1'b0);
        queue_cmd(OP_LIST,     '0, '0, 1'b1);
        for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++)
            queue_cmd(OP_W'(op), pick_value(), POS_W'($urandom_range(0, 63)), 1'b0);
        queue_cmd(OP_REM_HEAD, '0, '0, 1'b0);
        queue_cmd(OP_REM_HEAD, '0, '0, 1'b0);
        queue_cmd(OP_LIST,     '0, '0, 1'b0);
        queue_cmd(OP_INS_POS,  pick_value(), 6'd5, 1'b0);
        queue_random_traffic();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_cmds.size() != 0 || start)
            @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (CAPACITY + 8) @(posedge clk);

        if (due_results.size() != 0)
        begin
            mismatch_count++;
            $display("%0t: %0d expected results never arrived", $time, due_results.size());
        end
        $display("commands sent %0d, results checked %0d, full-list reads %0d",
                 cmds_sent, results_checked, n_list_reads);
        $display("rejected inserts: %0d full, %0d bad position; %0d empty-list hits",
                 n_full, n_badpos, n_empty);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
